// ===== rtl/stsp_pkg.sv =====
`default_nettype none

package stsp_pkg;

  localparam int NUM_MOTORS_DEF = 3;

  localparam int KIND_W  = 2;
  localparam int MSEL_W  = 2;
  localparam int POS_W   = 32;
  localparam int RATE_W  = 16;
  localparam int CFG_W   = 16;
  localparam int SEG_W   = 7;
  localparam int PULSE_W = 32;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int UPC_W   = 5;

  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [UPC_W-1:0]   upc_t;

  localparam cfg_t   DEF_RAMP    = cfg_t'(400);
  localparam cfg_t   DEF_MIN     = cfg_t'(50);
  localparam rate_t  RATE_FLOOR  = rate_t'(10);
  localparam rate_t  RECIP10     = rate_t'(52429);
  localparam int     RECIP_SHIFT = 19;
  localparam int     SEGQ_W      = 2 * RATE_W - RECIP_SHIFT;
  localparam seg_t   SEG_MAX     = seg_t'(100);
  localparam pulse_t NEAR_DIST   = pulse_t'(2);
  localparam int     DIV_STEPS   = RATE_W;

  localparam logic [MSEL_W-1:0] MOT_Z = MSEL_W'(0);
  localparam logic [MSEL_W-1:0] MOT_X = MSEL_W'(1);
  localparam logic [MSEL_W-1:0] MOT_B = MSEL_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_START,
    KIND_SEG_DONE,
    KIND_STOP,
    KIND_STOP_ALL
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACCEL,
    PH_CRUISE,
    PH_DECEL
  } phase_t;

  typedef enum logic [2:0] {
    CFG_RAMP_Z,
    CFG_RAMP_X,
    CFG_RAMP_X_OSC,
    CFG_RAMP_B,
    CFG_MIN_Z,
    CFG_MIN_X,
    CFG_MIN_X_OSC,
    CFG_MIN_B
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_START_CHK,
    OP_DIST,
    OP_NEAR,
    OP_INIT,
    OP_ADVANCE,
    OP_REMAIN,
    OP_PHASE,
    OP_RATE_PREP,
    OP_RATE_PEAK,
    OP_SPAN_MUL,
    OP_DIV_START,
    OP_RATE_ADD,
    OP_SEG_MUL,
    OP_SEG_SET,
    OP_STOP,
    OP_STOP_ALL,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_NO_CMD,
    C_REFUSE,
    C_NEAR,
    C_IDLE,
    C_FINISH,
    C_AT_PEAK,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ucode_t;

  typedef struct packed {
    logic                 start;
    logic [2*RATE_W-1:0]  dividend;
    cfg_t                 divisor;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    rate_t quotient;
  } div_rsp_t;

  // microprogram labels
  localparam upc_t U_FETCH     = upc_t'(0);
  localparam upc_t U_DECODE    = upc_t'(1);
  localparam upc_t U_ST_CHK    = upc_t'(2);
  localparam upc_t U_ST_DIST   = upc_t'(3);
  localparam upc_t U_ST_NEAR   = upc_t'(4);
  localparam upc_t U_ST_INIT   = upc_t'(5);
  localparam upc_t U_SC_CHK    = upc_t'(6);
  localparam upc_t U_SC_ADV    = upc_t'(7);
  localparam upc_t U_SC_REM    = upc_t'(8);
  localparam upc_t U_SC_PH     = upc_t'(9);
  localparam upc_t U_ISS       = upc_t'(10);
  localparam upc_t U_ISS_CAP   = upc_t'(11);
  localparam upc_t U_ISS_MUL   = upc_t'(12);
  localparam upc_t U_ISS_DIV   = upc_t'(13);
  localparam upc_t U_ISS_WAIT  = upc_t'(14);
  localparam upc_t U_ISS_ADD   = upc_t'(15);
  localparam upc_t U_SEG       = upc_t'(16);
  localparam upc_t U_SEG_SET   = upc_t'(17);
  localparam upc_t U_STOP      = upc_t'(18);
  localparam upc_t U_STOP_ALL  = upc_t'(19);
  localparam upc_t U_EMIT_WAIT = upc_t'(20);
  localparam upc_t U_EMIT      = upc_t'(21);

  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: U_FETCH};
    unique case (a)
      U_FETCH:     w = '{op: OP_NOP,       cond: C_NO_CMD,   target: U_FETCH};
      U_DECODE:    w = '{op: OP_LOAD,      cond: C_DISPATCH, target: U_FETCH};
      U_ST_CHK:    w = '{op: OP_START_CHK, cond: C_REFUSE,   target: U_EMIT_WAIT};
      U_ST_DIST:   w = '{op: OP_DIST,      cond: C_NEXT,     target: U_FETCH};
      U_ST_NEAR:   w = '{op: OP_NEAR,      cond: C_NEAR,     target: U_EMIT_WAIT};
      U_ST_INIT:   w = '{op: OP_INIT,      cond: C_ALWAYS,   target: U_ISS};
      U_SC_CHK:    w = '{op: OP_NOP,       cond: C_IDLE,     target: U_EMIT_WAIT};
      U_SC_ADV:    w = '{op: OP_ADVANCE,   cond: C_FINISH,   target: U_EMIT_WAIT};
      U_SC_REM:    w = '{op: OP_REMAIN,    cond: C_NEXT,     target: U_FETCH};
      U_SC_PH:     w = '{op: OP_PHASE,     cond: C_NEXT,     target: U_FETCH};
      U_ISS:       w = '{op: OP_RATE_PREP, cond: C_NEXT,     target: U_FETCH};
      U_ISS_CAP:   w = '{op: OP_RATE_PEAK, cond: C_AT_PEAK,  target: U_SEG};
      U_ISS_MUL:   w = '{op: OP_SPAN_MUL,  cond: C_NEXT,     target: U_FETCH};
      U_ISS_DIV:   w = '{op: OP_DIV_START, cond: C_NEXT,     target: U_FETCH};
      U_ISS_WAIT:  w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: U_ISS_WAIT};
      U_ISS_ADD:   w = '{op: OP_RATE_ADD,  cond: C_NEXT,     target: U_FETCH};
      U_SEG:       w = '{op: OP_SEG_MUL,   cond: C_NEXT,     target: U_FETCH};
      U_SEG_SET:   w = '{op: OP_SEG_SET,   cond: C_ALWAYS,   target: U_EMIT_WAIT};
      U_STOP:      w = '{op: OP_STOP,      cond: C_ALWAYS,   target: U_EMIT_WAIT};
      U_STOP_ALL:  w = '{op: OP_STOP_ALL,  cond: C_ALWAYS,   target: U_EMIT_WAIT};
      U_EMIT_WAIT: w = '{op: OP_NOP,       cond: C_OUT_BUSY, target: U_EMIT_WAIT};
      U_EMIT:      w = '{op: OP_EMIT,      cond: C_ALWAYS,   target: U_FETCH};
      default:     w = '{op: OP_NOP,       cond: C_ALWAYS,   target: U_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stsp_div.sv =====
`default_nettype none

module stsp_div
  import stsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0] cnt;
  cfg_t             divisor;
  rate_t            rem;
  rate_t            quo;
  logic [RATE_W:0]  shifted;
  logic [RATE_W:0]  trial;
  logic             ge;

  // high half is below the divisor, so the quotient fits RATE_W bits
  always_comb begin
    shifted = {rem, quo[RATE_W-1]};
    trial   = shifted - {1'b0, divisor};
    ge      = (shifted >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= CNT_W'(DIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.dividend[2*RATE_W-1:RATE_W];
      quo     <= req.dividend[RATE_W-1:0];
      divisor <= req.divisor;
    end else if (cnt != '0) begin
      rem <= ge ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
      quo <= {quo[RATE_W-2:0], ge};
    end
  end

  assign rsp.busy     = (cnt != '0);
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/stepper_trapezoid_segment_planner_core.sv =====
// Each item runs its microcode path from fetch to emit; an item that issues a ramp
// segment takes longest, as it waits on the serial divide for the ramp fraction.
// One item at a time: the next command is taken once the sequencer is back at fetch.
// Reset: synchronous; all motors idle, ramp registers 400, minimum registers 50.
`default_nettype none

module stepper_trapezoid_segment_planner_core
  import stsp_pkg::*;
#(
  parameter int NUM_MOTORS = NUM_MOTORS_DEF
)
(
  input  wire logic                clk,
  input  wire logic                rst,

  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [MSEL_W-1:0]   motor_select,
  input  wire logic signed [POS_W-1:0] target_position,
  input  wire logic [RATE_W-1:0]   peak_rate,
  input  wire logic                oscillation_mode,
  input  wire logic signed [POS_W-1:0] current_position,

  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output logic                     accepted,
  output logic                     issue_segment,
  output logic [SEG_W-1:0]         segment_pulses,
  output logic                     segment_dir,
  output logic [RATE_W-1:0]        segment_rate,
  output logic                     stop_generator,
  output logic                     done_event,
  output logic                     move_active,

  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int MIW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int MXW = MIW + MSEL_W;

  // configuration registers
  cfg_t ramp_len_z, ramp_len_x, ramp_len_x_osc, ramp_len_b;
  cfg_t min_rate_z, min_rate_x, min_rate_x_osc, min_rate_b;
  cfg_idx_t cfg_idx;
  logic     cfg_wr;
  cfg_t     cfg_rd;

  // sequencer
  upc_t   upc, upc_next;
  ucode_t uw;
  logic   cond_true;
  upc_t   dispatch;

  // captured command
  kind_t                kind_r;
  logic [MSEL_W-1:0]    mot;
  logic [POS_W-1:0]     tgt, cur;
  rate_t                pk_in;
  logic                 osc_in;
  logic [MXW-1:0]       mot_ext;
  logic [MIW-1:0]       midx;
  logic                 mot_ok;

  // per-motor state
  logic   active   [NUM_MOTORS];
  phase_t phase    [NUM_MOTORS];
  pulse_t total    [NUM_MOTORS];
  pulse_t sent     [NUM_MOTORS];
  seg_t   last_seg [NUM_MOTORS];
  logic   dir      [NUM_MOTORS];
  rate_t  peak     [NUM_MOTORS];
  logic   osc_flag [NUM_MOTORS];

  // datapath
  cfg_t                ramp_r, min_r;
  logic [POS_W:0]      diff_r;
  pulse_t              dist_r, num_r, rem_r;
  rate_t               span_r, rate_r;
  logic [2*RATE_W-1:0] prod_r, seg_prod;
  logic                osc_sel;
  cfg_t                ramp_sel, min_sel;
  logic [PULSE_W:0]    adv_sum;
  logic                adv_fin;
  phase_t              phase_next;
  rate_t               rate_fl;
  logic [SEGQ_W-1:0]   seg_q;
  seg_t                seg_c, seg_val;
  pulse_t              num_sel;

  // result being built
  logic  res_accepted, res_issue, res_dir, res_stop, res_done, res_active;
  seg_t  res_pulses;
  rate_t res_rate;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_len_z     <= DEF_RAMP;
      ramp_len_x     <= DEF_RAMP;
      ramp_len_x_osc <= DEF_RAMP;
      ramp_len_b     <= DEF_RAMP;
      min_rate_z     <= DEF_MIN;
      min_rate_x     <= DEF_MIN;
      min_rate_x_osc <= DEF_MIN;
      min_rate_b     <= DEF_MIN;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_RAMP_Z:     ramp_len_z     <= pwdata[CFG_W-1:0];
        CFG_RAMP_X:     ramp_len_x     <= pwdata[CFG_W-1:0];
        CFG_RAMP_X_OSC: ramp_len_x_osc <= pwdata[CFG_W-1:0];
        CFG_RAMP_B:     ramp_len_b     <= pwdata[CFG_W-1:0];
        CFG_MIN_Z:      min_rate_z     <= pwdata[CFG_W-1:0];
        CFG_MIN_X:      min_rate_x     <= pwdata[CFG_W-1:0];
        CFG_MIN_X_OSC:  min_rate_x_osc <= pwdata[CFG_W-1:0];
        CFG_MIN_B:      min_rate_b     <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_RAMP_Z:     cfg_rd = ramp_len_z;
      CFG_RAMP_X:     cfg_rd = ramp_len_x;
      CFG_RAMP_X_OSC: cfg_rd = ramp_len_x_osc;
      CFG_RAMP_B:     cfg_rd = ramp_len_b;
      CFG_MIN_Z:      cfg_rd = min_rate_z;
      CFG_MIN_X:      cfg_rd = min_rate_x;
      CFG_MIN_X_OSC:  cfg_rd = min_rate_x_osc;
      CFG_MIN_B:      cfg_rd = min_rate_b;
    endcase
    prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_rd};
  end

  // ---------------------------------------------------------------- command capture
  assign cmd_stall = (upc != U_FETCH);

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      kind_r <= kind_t'(kind);
      mot    <= motor_select;
      tgt    <= target_position;
      cur    <= current_position;
      pk_in  <= peak_rate;
      osc_in <= oscillation_mode;
    end
  end

  assign mot_ext = {{MIW{1'b0}}, mot};
  assign midx    = mot_ext[MIW-1:0];
  assign mot_ok  = (mot_ext < MXW'(NUM_MOTORS));

  // ---------------------------------------------------------------- sequencer
  assign uw = ucode_rom(upc);

  always_comb begin
    priority if (kind_r == KIND_STOP_ALL) begin
      dispatch = U_STOP_ALL;
    end else if (!mot_ok) begin
      dispatch = U_EMIT_WAIT;
    end else if (kind_r == KIND_START) begin
      dispatch = U_ST_CHK;
    end else if (kind_r == KIND_SEG_DONE) begin
      dispatch = U_SC_CHK;
    end else begin
      dispatch = U_STOP;
    end
  end

  always_comb begin
    unique case (uw.cond)
      C_NEXT:     cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_DISPATCH: cond_true = 1'b1;
      C_NO_CMD:   cond_true = !cmd_valid;
      C_REFUSE:   cond_true = active[midx] || (pk_in < min_r);
      C_NEAR:     cond_true = (dist_r <= NEAR_DIST);
      C_IDLE:     cond_true = !active[midx];
      C_FINISH:   cond_true = adv_fin;
      C_AT_PEAK:  cond_true = (phase[midx] == PH_CRUISE) ||
                              (num_r >= {{(PULSE_W-CFG_W){1'b0}}, ramp_r});
      C_DIV_BUSY: cond_true = div_rsp.busy;
      C_OUT_BUSY: cond_true = rsp_valid && rsp_stall;
      default:    cond_true = 1'b1;
    endcase
    if (uw.cond == C_DISPATCH) begin
      upc_next = dispatch;
    end else if (cond_true) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // ---------------------------------------------------------------- datapath logic
  always_comb begin
    osc_sel = (kind_r == KIND_START) ? osc_in : osc_flag[midx];
    priority if (mot == MOT_X && osc_sel) begin
      ramp_sel = ramp_len_x_osc;
      min_sel  = min_rate_x_osc;
    end else if (mot == MOT_Z) begin
      ramp_sel = ramp_len_z;
      min_sel  = min_rate_z;
    end else if (mot == MOT_X) begin
      ramp_sel = ramp_len_x;
      min_sel  = min_rate_x;
    end else if (mot == MOT_B) begin
      ramp_sel = ramp_len_b;
      min_sel  = min_rate_b;
    end else begin
      ramp_sel = DEF_RAMP;
      min_sel  = DEF_MIN;
    end
  end

  assign adv_sum = {1'b0, sent[midx]} + {{(PULSE_W+1-SEG_W){1'b0}}, last_seg[midx]};
  assign adv_fin = (adv_sum >= {1'b0, total[midx]});

  always_comb begin
    phase_next = phase[midx];
    if (phase[midx] == PH_ACCEL &&
        sent[midx] >= {{(PULSE_W-CFG_W){1'b0}}, ramp_r}) begin
      phase_next = (rem_r <= {{(PULSE_W-CFG_W){1'b0}}, ramp_r}) ? PH_DECEL : PH_CRUISE;
    end else if (phase[midx] == PH_CRUISE &&
                 rem_r <= {{(PULSE_W-CFG_W){1'b0}}, ramp_r}) begin
      phase_next = PH_DECEL;
    end
  end

  assign num_sel = (phase[midx] == PH_DECEL) ? (total[midx] - sent[midx]) : sent[midx];

  // segment = rate/10 by reciprocal, clamped to 1..100 and to what is left
  always_comb begin
    rate_fl = (rate_r < RATE_FLOOR) ? RATE_FLOOR : rate_r;
    seg_q   = seg_prod[2*RATE_W-1:RECIP_SHIFT];
    seg_c   = (seg_q > SEGQ_W'(SEG_MAX)) ? SEG_MAX : seg_q[SEG_W-1:0];
    seg_val = ({{(PULSE_W-SEG_W){1'b0}}, seg_c} > rem_r) ? rem_r[SEG_W-1:0] : seg_c;
  end

  assign div_req.start    = (uw.op == OP_DIV_START);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = ramp_r;

  stsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_LOAD: begin
        ramp_r       <= ramp_sel;
        min_r        <= min_sel;
        diff_r       <= {tgt[POS_W-1], tgt} - {cur[POS_W-1], cur};
        res_accepted <= 1'b0;
        res_issue    <= 1'b0;
        res_pulses   <= '0;
        res_dir      <= 1'b0;
        res_rate     <= '0;
        res_stop     <= 1'b0;
        res_done     <= 1'b0;
        res_active   <= 1'b0;
      end
      OP_START_CHK: res_active <= active[midx];
      OP_DIST: begin
        dist_r       <= diff_r[POS_W] ? pulse_t'(~diff_r + 1'b1) : diff_r[PULSE_W-1:0];
        res_accepted <= 1'b1;
      end
      OP_NEAR:  res_done <= (dist_r <= NEAR_DIST);
      OP_ADVANCE: begin
        if (adv_fin) begin
          res_stop <= 1'b1;
          res_done <= 1'b1;
        end
      end
      OP_REMAIN: rem_r <= total[midx] - sent[midx];
      OP_RATE_PREP: begin
        num_r  <= num_sel;
        rem_r  <= total[midx] - sent[midx];
        span_r <= (peak[midx] > min_r) ? (peak[midx] - min_r) : '0;
      end
      OP_RATE_PEAK: rate_r   <= peak[midx];
      OP_SPAN_MUL:  prod_r   <= (2*RATE_W)'(span_r) * (2*RATE_W)'(num_r[RATE_W-1:0]);
      OP_RATE_ADD:  rate_r   <= min_r + div_rsp.quotient;
      OP_SEG_MUL:   seg_prod <= (2*RATE_W)'(rate_fl) * (2*RATE_W)'(RECIP10);
      OP_SEG_SET: begin
        res_issue  <= 1'b1;
        res_pulses <= seg_val;
        res_dir    <= dir[midx];
        res_rate   <= rate_r;
        res_active <= 1'b1;
      end
      OP_STOP:     res_stop <= 1'b1;
      OP_STOP_ALL: res_stop <= 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- motor state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        active[m] <= 1'b0;
        phase[m]  <= PH_IDLE;
      end
    end else begin
      unique case (uw.op)
        OP_INIT: begin
          active[midx] <= 1'b1;
          phase[midx]  <= (dist_r <= {{(PULSE_W-CFG_W){1'b0}}, ramp_r}) ? PH_DECEL : PH_ACCEL;
        end
        OP_ADVANCE: begin
          if (adv_fin) begin
            active[midx] <= 1'b0;
            phase[midx]  <= PH_IDLE;
          end
        end
        OP_PHASE: phase[midx] <= phase_next;
        OP_STOP: begin
          active[midx] <= 1'b0;
          phase[midx]  <= PH_IDLE;
        end
        OP_STOP_ALL: begin
          for (int m = 0; m < NUM_MOTORS; m++) begin
            active[m] <= 1'b0;
            phase[m]  <= PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_INIT: begin
        peak[midx]     <= pk_in;
        total[midx]    <= dist_r;
        sent[midx]     <= '0;
        dir[midx]      <= diff_r[POS_W];
        osc_flag[midx] <= osc_in;
      end
      OP_ADVANCE: begin
        sent[midx] <= adv_fin ? total[midx] : adv_sum[PULSE_W-1:0];
        if (adv_fin) begin
          osc_flag[midx] <= 1'b0;
        end
      end
      OP_SEG_SET: last_seg[midx] <= seg_val;
      OP_STOP:    osc_flag[midx] <= 1'b0;
      OP_STOP_ALL: begin
        for (int m = 0; m < NUM_MOTORS; m++) begin
          osc_flag[m] <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (uw.op == OP_EMIT) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_EMIT) begin
      accepted       <= res_accepted;
      issue_segment  <= res_issue;
      segment_pulses <= res_pulses;
      segment_dir    <= res_dir;
      segment_rate   <= res_rate;
      stop_generator <= res_stop;
      done_event     <= res_done;
      move_active    <= res_active;
    end
  end

  // ---------------------------------------------------------------- checks
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && issue_segment |-> segment_pulses != '0 && segment_pulses <= SEG_MAX)
    else $error("segment pulse count out of range");

  a_seg_not_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(issue_segment && done_event))
    else $error("segment issued together with done");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    uw.op == OP_EMIT |-> !rsp_valid)
    else $error("result overwritten before it was taken");

  for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_motor_chk
    a_active_phase: assert property (@(posedge clk) disable iff (rst)
      active[g] == (phase[g] != PH_IDLE))
      else $error("active flag and phase disagree");
  end

endmodule

`default_nettype wire

// ===== tb/stepper_trapezoid_segment_planner_core_tb.sv =====
module stepper_trapezoid_segment_planner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stsp_pkg::*;

  typedef struct packed {
    kind_t                   kind;
    logic [MSEL_W-1:0]       motor;
    logic signed [POS_W-1:0] target;
    rate_t                   peak;
    logic                    osc;
    logic signed [POS_W-1:0] cur;
  } cmd_item_t;

  typedef struct packed {
    logic  accepted;
    logic  issue_segment;
    seg_t  segment_pulses;
    logic  segment_dir;
    rate_t segment_rate;
    logic  stop_generator;
    logic  done_event;
    logic  move_active;
  } plan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cmd_valid;
  logic                    cmd_stall;
  logic [KIND_W-1:0]       kind;
  logic [MSEL_W-1:0]       motor_select;
  logic signed [POS_W-1:0] target_position;
  logic [RATE_W-1:0]       peak_rate;
  logic                    oscillation_mode;
  logic signed [POS_W-1:0] current_position;

  logic                    rsp_valid;
  logic                    rsp_stall = 1'b0;
  logic                    accepted;
  logic                    issue_segment;
  logic [SEG_W-1:0]        segment_pulses;
  logic                    segment_dir;
  logic [RATE_W-1:0]       segment_rate;
  logic                    stop_generator;
  logic                    done_event;
  logic                    move_active;

  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  stepper_trapezoid_segment_planner_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // planner state as the testbench sees it
  cfg_t        cfg_reg   [0:7];
  bit          mv_active [0:NUM_MOTORS_DEF-1];
  phase_t      mv_phase  [0:NUM_MOTORS_DEF-1];
  pulse_t      mv_total  [0:NUM_MOTORS_DEF-1];
  pulse_t      mv_sent   [0:NUM_MOTORS_DEF-1];
  seg_t        mv_last   [0:NUM_MOTORS_DEF-1];
  bit          mv_dir    [0:NUM_MOTORS_DEF-1];
  rate_t       mv_peak   [0:NUM_MOTORS_DEF-1];
  bit          mv_osc    [0:NUM_MOTORS_DEF-1];

  plan_result_t planned_results[$];
  int          mismatch_count = 0;
  int          useful_items = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold = 0;

  function automatic cfg_t ramp_for(input logic [MSEL_W-1:0] m, input bit osc);
    case (m)
      MOT_Z: return cfg_reg[CFG_RAMP_Z];
      MOT_X: return osc ? cfg_reg[CFG_RAMP_X_OSC] : cfg_reg[CFG_RAMP_X];
      default: return cfg_reg[CFG_RAMP_B];
    endcase
  endfunction

  function automatic cfg_t min_for(input logic [MSEL_W-1:0] m, input bit osc);
    case (m)
      MOT_Z: return cfg_reg[CFG_MIN_Z];
      MOT_X: return osc ? cfg_reg[CFG_MIN_X_OSC] : cfg_reg[CFG_MIN_X];
      default: return cfg_reg[CFG_MIN_B];
    endcase
  endfunction

  // min + floor((peak - min) * num / ramp), fraction capped at one
  function automatic rate_t profile_rate(input rate_t mn, input rate_t pk, input pulse_t num,
                                         input cfg_t ramp);
    longint unsigned span;
    longint unsigned q;
    if (num >= ramp) return pk;
    span = (pk > mn) ? longint'(pk - mn) : 0;
    q = mn + (span * num) / ramp;
    return rate_t'(q);
  endfunction

  function automatic rate_t rate_for(input logic [MSEL_W-1:0] m);
    cfg_t ramp;
    cfg_t mn;
    ramp = ramp_for(m, mv_osc[m]);
    mn   = min_for(m, mv_osc[m]);
    case (mv_phase[m])
      PH_ACCEL:  return profile_rate(mn, mv_peak[m], mv_sent[m], ramp);
      PH_CRUISE: return mv_peak[m];
      PH_DECEL:  return profile_rate(mn, mv_peak[m], mv_total[m] - mv_sent[m], ramp);
      default:   return mn;
    endcase
  endfunction

  function automatic seg_t pulses_for(input rate_t rate, input pulse_t remaining);
    int unsigned s;
    s = ((rate < RATE_FLOOR) ? RATE_FLOOR : rate) / 10;
    if (s > SEG_MAX) s = SEG_MAX;
    if (s > remaining) s = remaining;
    return seg_t'(s);
  endfunction

  function automatic void park_motor(input int m);
    mv_active[m] = 1'b0;
    mv_phase[m]  = PH_IDLE;
    mv_osc[m]    = 1'b0;
  endfunction

  function automatic void take_segment(input logic [MSEL_W-1:0] m, inout plan_result_t r);
    rate_t rate;
    seg_t  n;
    rate = rate_for(m);
    n = pulses_for(rate, mv_total[m] - mv_sent[m]);
    mv_last[m]       = n;
    r.issue_segment  = 1'b1;
    r.segment_pulses = n;
    r.segment_dir    = mv_dir[m];
    r.segment_rate   = rate;
  endfunction

  function automatic void plan_item(input cmd_item_t c, output plan_result_t r,
                                    output bit ignored);
    logic [MSEL_W-1:0] m;
    longint            diff;
    longint unsigned   travel;
    longint unsigned   s;
    pulse_t            remaining;
    cfg_t              ramp;
    m = c.motor;
    r = '0;
    ignored = 1'b0;
    if (c.kind == KIND_STOP_ALL) begin
      for (int i = 0; i < NUM_MOTORS_DEF; i++) park_motor(i);
      r.stop_generator = 1'b1;
      return;
    end
    if (m >= NUM_MOTORS_DEF) begin
      ignored = 1'b1;
      return;
    end
    case (c.kind)
      KIND_START: begin
        if (mv_active[m] || c.peak < min_for(m, c.osc)) begin
          r.move_active = mv_active[m];
          return;
        end
        diff = longint'($signed(c.target)) - longint'($signed(c.cur));
        travel = (diff < 0) ? -diff : diff;
        r.accepted = 1'b1;
        if (travel <= NEAR_DIST) begin
          r.done_event = 1'b1;
          return;
        end
        mv_active[m] = 1'b1;
        mv_peak[m]   = c.peak;
        mv_total[m]  = pulse_t'(travel);
        mv_sent[m]   = '0;
        mv_dir[m]    = (diff > 0) ? 1'b0 : 1'b1;
        mv_osc[m]    = c.osc;
        mv_phase[m]  = (pulse_t'(travel) <= ramp_for(m, c.osc)) ? PH_DECEL : PH_ACCEL;
        take_segment(m, r);
        r.move_active = 1'b1;
      end
      KIND_STOP: begin
        park_motor(m);
        r.stop_generator = 1'b1;
      end
      default: begin
        if (!mv_active[m]) begin
          ignored = 1'b1;
          return;
        end
        s = mv_sent[m];
        s += mv_last[m];
        if (s >= mv_total[m]) begin
          mv_sent[m] = mv_total[m];
          park_motor(m);
          r.stop_generator = 1'b1;
          r.done_event     = 1'b1;
          return;
        end
        mv_sent[m] = pulse_t'(s);
        remaining  = mv_total[m] - mv_sent[m];
        ramp       = ramp_for(m, mv_osc[m]);
        if (mv_phase[m] == PH_ACCEL && mv_sent[m] >= ramp)
          mv_phase[m] = (remaining <= ramp) ? PH_DECEL : PH_CRUISE;
        else if (mv_phase[m] == PH_CRUISE && remaining <= ramp)
          mv_phase[m] = PH_DECEL;
        take_segment(m, r);
        r.move_active = 1'b1;
      end
    endcase
  endfunction

  function automatic cmd_item_t mk_item(input kind_t k, input logic [MSEL_W-1:0] m,
                                        input logic signed [POS_W-1:0] tgt,
                                        input logic signed [POS_W-1:0] cur,
                                        input rate_t pk, input logic osc);
    cmd_item_t c;
    c.kind = k;
    c.motor = m;
    c.target = tgt;
    c.cur = cur;
    c.peak = pk;
    c.osc = osc;
    return c;
  endfunction

  // mostly coherent moves: starts followed by completions on active motors
  function automatic cmd_item_t random_item();
    cmd_item_t c;
    int unsigned pick;
    int unsigned d;
    logic [MSEL_W-1:0] m;
    longint unsigned pk;
    c = '0;
    c.kind   = kind_t'($urandom_range(0, 3));
    c.motor  = $urandom;
    c.target = $urandom;
    c.cur    = $urandom;
    c.peak   = $urandom;
    c.osc    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 62 && (mv_active[0] || mv_active[1] || mv_active[2])) begin
      do m = $urandom_range(0, NUM_MOTORS_DEF - 1); while (!mv_active[m]);
      c.kind  = KIND_SEG_DONE;
      c.motor = m;
    end else if (pick < 88) begin
      m = $urandom_range(0, NUM_MOTORS_DEF - 1);
      c.kind  = KIND_START;
      c.motor = m;
      if ($urandom_range(0, 9) != 0) begin
        pk = min_for(m, c.osc) + $urandom_range(0, 1500);
        c.peak = (pk > 16'hFFFF) ? 16'hFFFF : rate_t'(pk);
      end
      case ($urandom_range(0, 9))
        0:       d = $urandom_range(0, 2);
        1:       d = $urandom;
        default: d = $urandom_range(3, 1200);
      endcase
      c.target = $urandom_range(0, 1) ? c.cur + d : c.cur - d;
    end else if (pick < 94) begin
      c.kind = KIND_STOP;
    end else if (pick < 96) begin
      c.kind = KIND_STOP_ALL;
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    plan_result_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (planned_results.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        w = planned_results.pop_front();
        check_field("accepted", accepted, w.accepted);
        check_field("issue_segment", issue_segment, w.issue_segment);
        check_field("segment_pulses", segment_pulses, w.segment_pulses);
        check_field("segment_dir", segment_dir, w.segment_dir);
        check_field("segment_rate", segment_rate, w.segment_rate);
        check_field("stop_generator", stop_generator, w.stop_generator);
        check_field("done_event", done_event, w.done_event);
        check_field("move_active", move_active, w.move_active);
      end
    end
  end

  // result side pacing: random stall bursts, or a long hold when asked
  always begin : rsp_pacer
    int n;
    @(negedge clk);
    if (rx_hold != 0) begin
      rsp_stall = 1'b1;
      n = rx_hold;
      repeat (n) @(negedge clk);
      rx_hold = 0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rsp_stall = 1'b1;
      n = $urandom_range(1, 14);
      repeat (n) @(negedge clk);
    end
    rsp_stall = 1'b0;
  end

  task automatic idle_cmd(input int n);
    @(negedge clk) cmd_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // valid stays high after the accept until the next falling edge
  task automatic send_item(input cmd_item_t c);
    plan_result_t r;
    bit ign;
    @(negedge clk);
    cmd_valid        = 1'b1;
    kind             = c.kind;
    motor_select     = c.motor;
    target_position  = c.target;
    peak_rate        = c.peak;
    oscillation_mode = c.osc;
    current_position = c.cur;
    do @(posedge clk); while (cmd_stall);
    plan_item(c, r, ign);
    planned_results.push_back(r);
    if (!ign) useful_items++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) idle_cmd($urandom_range(1, 14));
  endtask

  task automatic wait_drain();
    @(negedge clk) cmd_valid = 1'b0;
    while (planned_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_t v);
    logic [DATA_W-1:0] rd;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = DATA_W'(v);
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    cfg_reg[idx] = v;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    do @(posedge clk); while (!pready);
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (rd !== DATA_W'(v))
      report_mismatch($sformatf("readback of %s got %0h want %0h", idx.name(), rd, v));
  endtask

  task automatic run_random(input int n);
    int goal;
    goal = useful_items + n;
    while (useful_items < goal) send_item(random_item());
  endtask

  task automatic apply_profile(input int sel);
    cfg_t v;
    wait_drain();
    for (int i = 0; i < 8; i++) begin
      case (sel)
        0: v = (i < 4) ? DEF_RAMP : DEF_MIN;
        1: v = (i < 4) ? cfg_t'($urandom_range(1, 30)) : cfg_t'($urandom_range(1, 200));
        2: v = (i % 2 == 0) ? ((i < 4) ? 16'd1 : 16'hFFFF) : ((i < 4) ? 16'hFFFF : 16'd1);
        default: v = (i < 4) ? cfg_t'($urandom_range(1, 2000)) : cfg_t'($urandom_range(1, 1000));
      endcase
      write_reg(cfg_idx_t'(i), v);
    end
  endtask

  task automatic test_directed_cases();
    send_item(mk_item(KIND_START, 2'd3, 32'sd500, 32'sd0, 16'd1000, 1'b0));
    send_item(mk_item(KIND_START, MOT_Z, 32'sd100, 32'sd0, 16'd49, 1'b0));
    send_item(mk_item(KIND_START, MOT_Z, 32'sd1002, 32'sd1000, 16'd500, 1'b0));
    send_item(mk_item(KIND_START, MOT_Z, -32'sd7, -32'sd5, 16'd500, 1'b1));
    send_item(mk_item(KIND_START, MOT_Z, 32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF, 1'b1));
    send_item(mk_item(KIND_START, MOT_Z, 32'sd10, 32'sd0, 16'd500, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_STOP, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_STOP, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_START, MOT_X, 32'sd300, 32'sd0, 16'd1000, 1'b1));
    send_item(mk_item(KIND_START, MOT_B, 32'sd0, 32'sd5000, 16'd400, 1'b0));
    send_item(mk_item(KIND_START, MOT_X, 32'sd900, 32'sd0, 16'd1000, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, MOT_X, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, MOT_B, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_STOP_ALL, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_STOP, 2'd3, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, 2'd3, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_START, MOT_Z, 32'sd3, 32'sd0, 16'hFFFF, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_START, MOT_B, 32'sh7FFFFFFF, 32'sh7FFFFFFC, 16'd50, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, MOT_B, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_STOP_ALL, 2'd3, 32'sd0, 32'sd0, 16'd0, 1'b1));
    wait_drain();
  endtask

  // minimum raised over the peak mid-move, then zero ramp and zero minimum
  task automatic test_config_extremes();
    send_item(mk_item(KIND_START, MOT_B, 32'sd3000, 32'sd0, 16'd1000, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, MOT_B, 32'sd0, 32'sd0, 16'd0, 1'b0));
    wait_drain();
    write_reg(CFG_MIN_B, 16'hFFFF);
    send_item(mk_item(KIND_SEG_DONE, MOT_B, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_SEG_DONE, MOT_B, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_STOP, MOT_B, 32'sd0, 32'sd0, 16'd0, 1'b0));
    wait_drain();
    write_reg(CFG_RAMP_Z, 16'd0);
    write_reg(CFG_MIN_Z, 16'd0);
    send_item(mk_item(KIND_START, MOT_Z, -32'sd50, 32'sd0, 16'd0, 1'b0));
    repeat (3) send_item(mk_item(KIND_SEG_DONE, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_STOP_ALL, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    send_item(mk_item(KIND_START, MOT_Z, 32'sd900, 32'sd0, 16'd700, 1'b0));
    repeat (4) send_item(mk_item(KIND_SEG_DONE, MOT_Z, 32'sd0, 32'sd0, 16'd0, 1'b0));
    wait_drain();
  endtask

  task automatic test_backpressure();
    apply_profile(0);
    rx_hold = 300;
    repeat (8) send_item(random_item());
    wait_drain();
    run_random(30);
    wait_drain();
  endtask

  task automatic test_random_profiles();
    for (int sel = 1; sel < 4; sel++) begin
      apply_profile(sel);
      run_random(190);
    end
    apply_profile(0);
    run_random(190);
  endtask

  task automatic test_steady_stream();
    wait_drain();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    apply_profile(3);
    run_random(120);
  endtask

  initial begin
    cmd_valid = 1'b0;
    kind = KIND_START;
    motor_select = '0;
    target_position = '0;
    peak_rate = '0;
    oscillation_mode = 1'b0;
    current_position = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < 8; i++) cfg_reg[i] = (i < 4) ? DEF_RAMP : DEF_MIN;
    for (int m = 0; m < NUM_MOTORS_DEF; m++) begin
      park_motor(m);
      mv_total[m] = '0;
      mv_sent[m]  = '0;
      mv_last[m]  = '0;
      mv_dir[m]   = 1'b0;
      mv_peak[m]  = '0;
    end
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    test_directed_cases();
    test_config_extremes();
    test_backpressure();
    test_random_profiles();
    test_steady_stream();

    wait_drain();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("stepper_trapezoid_segment_planner_core regression: pass");
    end else begin
      $display("stepper_trapezoid_segment_planner_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("stepper_trapezoid_segment_planner_core regression: fail");
    $finish;
  end

endmodule
